### design/char_lcd_4bit_command_sequencer_assert.svh
// assertion macros used by the lcd sequencer (lcdseq_useq)
// expects clk_i and rst_ni in the scope of use
`ifndef CHAR_LCD_4BIT_COMMAND_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_4BIT_COMMAND_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define LCDSEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCDSEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lcdseq_pkg.sv
`default_nettype none

package lcdseq_pkg;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        char_code;
    logic signed [7:0] column;
    logic [1:0]        row;
    logic [2:0]        glyph_slot;
    logic [2:0]        glyph_row;
    logic [7:0]        glyph_bits;
  } lcd_req_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       wait_busy;
    logic [3:0] delay_before_ms;
    logic [2:0] delay_after_ms;
    logic       last;
  } lcd_res_t;

  typedef enum logic [1:0] {
    CMD_PUT_CHAR = 2'd0,
    CMD_GOTO     = 2'd1,
    CMD_INIT     = 2'd2,
    CMD_CGRAM    = 2'd3
  } cmd_e;

  // control characters
  localparam logic [7:0] ChFormFeed  = 8'h0C;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChBackspace = 8'h08;

  // instruction bytes and fields, newline target position
  localparam logic [7:0] InsShiftLeft  = 8'h10;
  localparam logic [7:0] InsDdramFlag  = 8'h80;
  localparam logic [1:0] InsCgramHi    = 2'b01;
  localparam logic [7:0] NewlineColumn = 8'h01;
  localparam logic [1:0] NewlineRow    = 2'd2;

  function automatic logic [7:0] line_base(input logic [1:0] row);
    logic [7:0] base;
    unique case (row)
      2'd0:    base = 8'h80;
      2'd1:    base = 8'hC0;
      2'd2:    base = 8'h94;
      default: base = 8'hD4;
    endcase
    return base;
  endfunction

  // microprogram layout
  localparam int unsigned PcW     = 5;
  localparam int unsigned ProgLen = 20;
  localparam logic [PcW-1:0] EntryInit  = PcW'(0);
  localparam logic [PcW-1:0] EntryByte  = PcW'(12);
  localparam logic [PcW-1:0] EntryCgram = PcW'(14);
  localparam logic [PcW-1:0] EntryClear = PcW'(18);

  typedef enum logic [2:0] {
    NIB_CONST  = 3'd0,
    NIB_OP0_HI = 3'd1,
    NIB_OP0_LO = 3'd2,
    NIB_OP1_HI = 3'd3,
    NIB_OP1_LO = 3'd4
  } nib_sel_e;

  typedef enum logic [1:0] {
    RS_INSTR = 2'd0,
    RS_DATA  = 2'd1,
    RS_REQ   = 2'd2
  } rs_sel_e;

  typedef struct packed {
    nib_sel_e   nib_sel;
    logic [3:0] konst;
    rs_sel_e    rs_sel;
    logic       busy;
    logic [3:0] before_ms;
    logic [2:0] after_ms;
    logic       last;
  } ucode_t;

  // dispatch result handed to the sequencer
  typedef struct packed {
    logic           go;
    logic [PcW-1:0] entry;
    logic [7:0]     op0;
    logic [7:0]     op1;
    logic           rs_data;
  } dispatch_t;

  function automatic ucode_t uw(input nib_sel_e sel, input logic [3:0] k, input rs_sel_e rs,
                                input logic busy, input logic [3:0] bef,
                                input logic [2:0] aft, input logic last);
    ucode_t w;
    w.nib_sel   = sel;
    w.konst     = k;
    w.rs_sel    = rs;
    w.busy      = busy;
    w.before_ms = bef;
    w.after_ms  = aft;
    w.last      = last;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      // wake-up nibbles
      5'd0:  w = uw(NIB_CONST, 4'h3, RS_INSTR, 1'b0, 4'd15, 3'd5, 1'b0);
      5'd1:  w = uw(NIB_CONST, 4'h3, RS_INSTR, 1'b0, 4'd0, 3'd5, 1'b0);
      5'd2:  w = uw(NIB_CONST, 4'h3, RS_INSTR, 1'b0, 4'd0, 3'd5, 1'b0);
      5'd3:  w = uw(NIB_CONST, 4'h2, RS_INSTR, 1'b0, 4'd0, 3'd0, 1'b0);
      // setup bytes: function set, display on, clear, entry mode
      5'd4:  w = uw(NIB_CONST, 4'h2, RS_INSTR, 1'b1, 4'd0, 3'd0, 1'b0);
      5'd5:  w = uw(NIB_CONST, 4'h8, RS_INSTR, 1'b0, 4'd0, 3'd0, 1'b0);
      5'd6:  w = uw(NIB_CONST, 4'h0, RS_INSTR, 1'b1, 4'd0, 3'd0, 1'b0);
      5'd7:  w = uw(NIB_CONST, 4'hC, RS_INSTR, 1'b0, 4'd0, 3'd0, 1'b0);
      5'd8:  w = uw(NIB_CONST, 4'h0, RS_INSTR, 1'b1, 4'd0, 3'd0, 1'b0);
      5'd9:  w = uw(NIB_CONST, 4'h1, RS_INSTR, 1'b0, 4'd0, 3'd0, 1'b0);
      5'd10: w = uw(NIB_CONST, 4'h0, RS_INSTR, 1'b1, 4'd0, 3'd0, 1'b0);
      5'd11: w = uw(NIB_CONST, 4'h6, RS_INSTR, 1'b0, 4'd0, 3'd0, 1'b1);
      // one byte from operand 0
      5'd12: w = uw(NIB_OP0_HI, 4'h0, RS_REQ, 1'b1, 4'd0, 3'd0, 1'b0);
      5'd13: w = uw(NIB_OP0_LO, 4'h0, RS_REQ, 1'b0, 4'd0, 3'd0, 1'b1);
      // cgram address then pattern
      5'd14: w = uw(NIB_OP0_HI, 4'h0, RS_INSTR, 1'b1, 4'd0, 3'd0, 1'b0);
      5'd15: w = uw(NIB_OP0_LO, 4'h0, RS_INSTR, 1'b0, 4'd0, 3'd0, 1'b0);
      5'd16: w = uw(NIB_OP1_HI, 4'h0, RS_DATA, 1'b1, 4'd0, 3'd0, 1'b0);
      5'd17: w = uw(NIB_OP1_LO, 4'h0, RS_DATA, 1'b0, 4'd0, 3'd0, 1'b1);
      // clear display, long wait after
      5'd18: w = uw(NIB_CONST, 4'h0, RS_INSTR, 1'b1, 4'd0, 3'd0, 1'b0);
      5'd19: w = uw(NIB_CONST, 4'h1, RS_INSTR, 1'b0, 4'd0, 3'd2, 1'b1);
      default: w = uw(NIB_CONST, 4'h0, RS_INSTR, 1'b0, 4'd0, 3'd0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### design/lcdseq_dispatch.sv
`default_nettype none

module lcdseq_dispatch (
  input  lcdseq_pkg::lcd_req_t  req_i,
  output lcdseq_pkg::dispatch_t dsp_o
);
  import lcdseq_pkg::*;

  logic [7:0] goto_addr;

  assign goto_addr = (line_base(req_i.row) + req_i.column[7:0]) | InsDdramFlag;

  always_comb begin
    dsp_o.go      = 1'b1;
    dsp_o.entry   = EntryByte;
    dsp_o.op0     = req_i.char_code;
    dsp_o.op1     = req_i.glyph_bits;
    dsp_o.rs_data = 1'b0;
    unique case (cmd_e'(req_i.cmd))
      CMD_PUT_CHAR: begin
        unique case (req_i.char_code)
          ChFormFeed:  dsp_o.entry = EntryClear;
          ChNewline:   dsp_o.op0 = (line_base(NewlineRow) + NewlineColumn) | InsDdramFlag;
          ChBackspace: dsp_o.op0 = InsShiftLeft;
          default:     dsp_o.rs_data = 1'b1;
        endcase
      end
      CMD_GOTO: begin
        dsp_o.go  = ~req_i.column[7];
        dsp_o.op0 = goto_addr;
      end
      CMD_INIT: dsp_o.entry = EntryInit;
      CMD_CGRAM: begin
        dsp_o.entry = EntryCgram;
        dsp_o.op0   = {InsCgramHi, req_i.glyph_slot, req_i.glyph_row};
      end
      default: dsp_o.go = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### design/lcdseq_useq.sv
`default_nettype none

module lcdseq_useq (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  lcdseq_pkg::dispatch_t     dsp_i,
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output lcdseq_pkg::lcd_res_t      out_res_o
);
  import lcdseq_pkg::*;

  logic           running_q, running_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic [7:0]     op0_q, op1_q;
  logic           rs_data_q;
  logic           out_valid_q, out_valid_d;
  lcd_res_t       out_res_q, out_res_d;
  ucode_t         word;
  logic           fire;
  logic [3:0]     nib;
  logic           rs;

  assign word = ucode_rom(pc_q);
  assign fire = running_q & (~out_valid_q | out_ready_i);

  always_comb begin
    case (word.nib_sel)
      NIB_OP0_HI: nib = op0_q[7:4];
      NIB_OP0_LO: nib = op0_q[3:0];
      NIB_OP1_HI: nib = op1_q[7:4];
      NIB_OP1_LO: nib = op1_q[3:0];
      default:    nib = word.konst;
    endcase
    case (word.rs_sel)
      RS_DATA: rs = 1'b1;
      RS_REQ:  rs = rs_data_q;
      default: rs = 1'b0;
    endcase
  end

  always_comb begin
    running_d   = running_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (start_i) begin
      running_d = 1'b1;
      pc_d      = dsp_i.entry;
    end else if (fire) begin
      pc_d = pc_q + PcW'(1);
      if (word.last) begin
        running_d = 1'b0;
      end
    end
    if (fire) begin
      out_valid_d               = 1'b1;
      out_res_d.reg_select      = rs;
      out_res_d.nibble          = nib;
      out_res_d.wait_busy       = word.busy;
      out_res_d.delay_before_ms = word.before_ms;
      out_res_d.delay_after_ms  = word.after_ms;
      out_res_d.last            = word.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      running_q   <= running_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
    if (start_i) begin
      op0_q     <= dsp_i.op0;
      op1_q     <= dsp_i.op1;
      rs_data_q <= dsp_i.rs_data;
    end
  end

  assign busy_o      = running_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

`include "char_lcd_4bit_command_sequencer_assert.svh"

  `LCDSEQ_ASSERT_IMPL(a_pc_in_program, running_q, pc_q < PcW'(ProgLen), "pc outside program")
  `LCDSEQ_ASSERT_NEXT(a_last_ends_run, fire && word.last, !running_q, "run continues past last")
  `LCDSEQ_ASSERT_NEXT(a_fire_fills_out, fire, out_valid_q && (out_res_q.last == $past(word.last)),
                      "issued step not in output register")

endmodule

`default_nettype wire

### design/char_lcd_4bit_command_sequencer.sv
// a taken request loads pc and operands; the first nibble is then registered
// throughput: one nibble per cycle while the output is taken, from a step counter
//   walking a microcode rom
// a go-to with negative column is taken and retires with no output
// reset: rst_ni asynchronous active low, clears run flag, pc and output valid
`default_nettype none

module char_lcd_4bit_command_sequencer (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  lcdseq_pkg::lcd_req_t  in_req_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output lcdseq_pkg::lcd_res_t  out_res_o
);
  import lcdseq_pkg::*;

  // decoded entry point and operand bytes for the incoming request
  dispatch_t dsp;
  // sequencer still walking a program
  logic      seq_busy;
  // a request transaction that starts a program
  logic      start;

  lcdseq_dispatch u_dispatch (
    .req_i (in_req_i),
    .dsp_o (dsp)
  );

  // a new request is taken whenever no program is running, even while the
  // last nibble of the previous one still sits in the output register
  assign in_ready_o = ~seq_busy;
  assign start      = in_valid_i & in_ready_o & dsp.go;

  lcdseq_useq u_useq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .dsp_i       (dsp),
    .busy_o      (seq_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule

`default_nettype wire
